[hdl/tmb_pkg.sv]
// Package for the tiled mask brighten block: sizing constants, register map,
// operation codes and the pixel scaling and dimension clamp functions.
// No dependencies.
`default_nettype none

package tmb_pkg;

  // Sizing
  localparam int TILE_DIM_MAX  = 64;
  localparam int FRAME_DIM_MAX = 4096;
  localparam int MASK_DEPTH    = TILE_DIM_MAX * TILE_DIM_MAX;
  localparam int MASK_AW       = $clog2(MASK_DEPTH);
  localparam int TILE_CW       = $clog2(TILE_DIM_MAX);
  localparam int FRAME_CW      = $clog2(FRAME_DIM_MAX);

  // Register field widths
  localparam int CFG_FRAME_W = 13;
  localparam int CFG_TILE_W  = 7;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  // Reset values of the dimension registers
  localparam logic [CFG_FRAME_W-1:0] FRAME_WIDTH_RST  = CFG_FRAME_W'(640);
  localparam logic [CFG_FRAME_W-1:0] FRAME_HEIGHT_RST = CFG_FRAME_W'(480);
  localparam logic [CFG_TILE_W-1:0]  TILE_WIDTH_RST   = CFG_TILE_W'(64);
  localparam logic [CFG_TILE_W-1:0]  TILE_HEIGHT_RST  = CFG_TILE_W'(64);

  // Register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_TILE_WIDTH   = 2'd2,
    REG_TILE_HEIGHT  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // floor(v*29/20) saturated to 255; x/20 done as x*3277 >> 16, exact for x < 7396
  localparam logic [11:0] DIV20_RECIP = 12'd3277;

  function automatic logic [7:0] brighten(input logic [7:0] v);
    logic [12:0] prod;
    logic [24:0] scaled;
    logic [8:0]  quot;
    prod   = 13'(v) * 13'd29;
    scaled = 25'(prod) * 25'(DIV20_RECIP);
    quot   = scaled[24:16];
    return (quot > 9'd255) ? 8'hFF : quot[7:0];
  endfunction

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CFG_FRAME_W-1:0] clamp_frame(input logic [CFG_FRAME_W-1:0] v);
    if (v == '0) return CFG_FRAME_W'(1);
    if (32'(v) > FRAME_DIM_MAX) return CFG_FRAME_W'(FRAME_DIM_MAX);
    return v;
  endfunction

  function automatic logic [CFG_TILE_W-1:0] clamp_tile(input logic [CFG_TILE_W-1:0] v);
    if (v == '0) return CFG_TILE_W'(1);
    if (32'(v) > TILE_DIM_MAX) return CFG_TILE_W'(TILE_DIM_MAX);
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/tmb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tmb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tiled_mask_brighten.sv]
// Top level of the tiled mask brighten block: APB register file, tile load,
// raster counters, mask RAM and the two-stage pixel pipeline.
// Depends on tmb_pkg and tmb_ram.
//
// Input channel (in_valid/in_ready): an operation and one RGB pixel. A load
// stores one tile mask bit (set when the pixel is all zero) at the next tile
// position, wrapping after tile_width*tile_height loads, with no result. A
// pixel takes the next raster position, the tile repeated over the frame, and
// gives one result on out_valid/out_ready, masked channels scaled by 1.45 and
// saturated to 255.
// An accepted pixel loads the read stage and the registered mask read at the
// accept edge; the output register loads when the read stage moves on to a
// free output. Throughput: one transaction per cycle while in_ready is high,
// loads and pixels freely interleaved.
// A stalled receiver holds the output register; one more pixel waits in the
// read stage, after which in_ready drops until the output drains.
// Reset (rst_n low, synchronous) clears the counters, the load index and the
// pipeline and restores 640x480 frame and 64x64 tile sizes; mask contents
// are not cleared. APB registers at byte offsets 0, 4, 8, 12: frame_width,
// frame_height, tile_width, tile_height. Write them only while idle.
`default_nettype none

module tiled_mask_brighten (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmb_pkg::APB_AW-1:0]    paddr,
  input  wire logic [tmb_pkg::APB_DW-1:0]    pwdata,
  output logic      [tmb_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [7:0]                    in_red,
  input  wire logic [7:0]                    in_green,
  input  wire logic [7:0]                    in_blue,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [7:0]                    out_red,
  output logic      [7:0]                    out_green,
  output logic      [7:0]                    out_blue,
  output logic                               out_brightened,
  output logic                               out_frame_end
);

  localparam int FW = tmb_pkg::CFG_FRAME_W;
  localparam int TW = tmb_pkg::CFG_TILE_W;
  localparam int CW = tmb_pkg::FRAME_CW;
  localparam int TC = tmb_pkg::TILE_CW;
  localparam int AW = tmb_pkg::MASK_AW;

  // ---------------- Configuration registers ----------------
  logic [FW-1:0] frame_width_r, frame_height_r;
  logic [TW-1:0] tile_width_r, tile_height_r;
  logic          cfg_wr;
  tmb_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = tmb_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= tmb_pkg::FRAME_WIDTH_RST;
      frame_height_r <= tmb_pkg::FRAME_HEIGHT_RST;
      tile_width_r   <= tmb_pkg::TILE_WIDTH_RST;
      tile_height_r  <= tmb_pkg::TILE_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tmb_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[FW-1:0];
        tmb_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[FW-1:0];
        tmb_pkg::REG_TILE_WIDTH:   tile_width_r   <= pwdata[TW-1:0];
        tmb_pkg::REG_TILE_HEIGHT:  tile_height_r  <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tmb_pkg::REG_FRAME_WIDTH:  prdata = tmb_pkg::APB_DW'(frame_width_r);
      tmb_pkg::REG_FRAME_HEIGHT: prdata = tmb_pkg::APB_DW'(frame_height_r);
      tmb_pkg::REG_TILE_WIDTH:   prdata = tmb_pkg::APB_DW'(tile_width_r);
      tmb_pkg::REG_TILE_HEIGHT:  prdata = tmb_pkg::APB_DW'(tile_height_r);
      default:                   prdata = '0;
    endcase
  end

  // Effective dimensions
  logic [FW-1:0] fw_c, fh_c;
  logic [TW-1:0] tw_c, th_c;
  assign fw_c = tmb_pkg::clamp_frame(frame_width_r);
  assign fh_c = tmb_pkg::clamp_frame(frame_height_r);
  assign tw_c = tmb_pkg::clamp_tile(tile_width_r);
  assign th_c = tmb_pkg::clamp_tile(tile_height_r);

  // ---------------- Handshake ----------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_move, in_acc, img_acc, load_acc;

  assign out_free = ~out_valid_r | out_ready;
  assign s1_move  = s1_valid_r & out_free;
  assign in_ready = ~s1_valid_r | out_free;
  assign in_acc   = in_valid & in_ready;
  assign img_acc  = in_acc & (in_operation == tmb_pkg::OP_PIXEL);
  assign load_acc = in_acc & (in_operation == tmb_pkg::OP_LOAD);

  // ---------------- Counters ----------------
  logic [AW-1:0] load_index_r, load_index_nxt;
  logic [CW-1:0] column_r, column_nxt, row_r, row_nxt;
  logic [TC-1:0] tile_column_r, tile_column_nxt, tile_row_r, tile_row_nxt;
  logic [AW-1:0] tile_row_base_r, tile_row_base_nxt;
  logic          last_col, last_row;
  logic [2*TW-1:0]  tile_area;
  logic [TC+TW-1:0] row_base_prod;
  logic [TC-1:0]    tile_row_inc;

  assign last_col      = (FW'(column_r) + FW'(1)) >= fw_c;
  assign last_row      = (FW'(row_r) + FW'(1)) >= fh_c;
  assign tile_area     = (2*TW)'(tw_c) * (2*TW)'(th_c);
  assign tile_row_inc  = tile_row_r + TC'(1);
  assign row_base_prod = (TC+TW)'(tile_row_inc) * (TC+TW)'(tw_c);

  always_comb begin
    load_index_nxt    = load_index_r;
    column_nxt        = column_r;
    row_nxt           = row_r;
    tile_column_nxt   = tile_column_r;
    tile_row_nxt      = tile_row_r;
    tile_row_base_nxt = tile_row_base_r;
    if (load_acc) begin
      if ((2*TW)'(load_index_r) + (2*TW)'(1) >= tile_area) begin
        load_index_nxt = '0;
      end else begin
        load_index_nxt = load_index_r + AW'(1);
      end
    end
    if (img_acc) begin
      if (!last_col) begin
        column_nxt = column_r + CW'(1);
        if (TW'(tile_column_r) + TW'(1) >= tw_c) begin
          tile_column_nxt = '0;
        end else begin
          tile_column_nxt = tile_column_r + TC'(1);
        end
      end else begin
        column_nxt      = '0;
        tile_column_nxt = '0;
        if (last_row) begin
          row_nxt           = '0;
          tile_row_nxt      = '0;
          tile_row_base_nxt = '0;
        end else begin
          row_nxt = row_r + CW'(1);
          if (TW'(tile_row_r) + TW'(1) >= th_c) begin
            tile_row_nxt      = '0;
            tile_row_base_nxt = '0;
          end else begin
            tile_row_nxt      = tile_row_inc;
            tile_row_base_nxt = row_base_prod[AW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_index_r    <= '0;
      column_r        <= '0;
      row_r           <= '0;
      tile_column_r   <= '0;
      tile_row_r      <= '0;
      tile_row_base_r <= '0;
    end else begin
      load_index_r    <= load_index_nxt;
      column_r        <= column_nxt;
      row_r           <= row_nxt;
      tile_column_r   <= tile_column_nxt;
      tile_row_r      <= tile_row_nxt;
      tile_row_base_r <= tile_row_base_nxt;
    end
  end

  // ---------------- Mask RAM ----------------
  // Loads write at their accept edge, pixels read at theirs; one transaction
  // per edge, so a read always sees every earlier load.
  logic [AW-1:0] mask_raddr;
  logic          mask_wdata, mask_rdata;

  assign mask_raddr = tile_row_base_r + AW'(tile_column_r);
  assign mask_wdata = (in_red == 8'd0) && (in_green == 8'd0) && (in_blue == 8'd0);

  tmb_ram #(
    .WIDTH (1),
    .DEPTH (tmb_pkg::MASK_DEPTH)
  ) u_mask_ram (
    .clk   (clk),
    .we    (load_acc),
    .waddr (load_index_r),
    .wdata (mask_wdata),
    .re    (img_acc),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  // ---------------- Read stage ----------------
  logic [7:0] s1_red_r, s1_green_r, s1_blue_r;
  logic       s1_fend_r;

  always_comb begin
    if (img_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (img_acc) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_fend_r  <= last_col & last_row;
    end
  end

  // ---------------- Output register ----------------
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_bright_r, out_fend_r;

  always_comb begin
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_red_r    <= mask_rdata ? tmb_pkg::brighten(s1_red_r)   : s1_red_r;
      out_green_r  <= mask_rdata ? tmb_pkg::brighten(s1_green_r) : s1_green_r;
      out_blue_r   <= mask_rdata ? tmb_pkg::brighten(s1_blue_r)  : s1_blue_r;
      out_bright_r <= mask_rdata;
      out_fend_r   <= s1_fend_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_brightened = out_bright_r;
  assign out_frame_end  = out_fend_r;

  // ---------------- Assertions ----------------
  // A pixel always lands in the read stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    img_acc |=> s1_valid_r)
    else $error("accepted pixel missing from read stage");

  // A load leaves the read stage empty (it was free or drained).
  assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !s1_valid_r)
    else $error("read stage holds stale pixel after load");

  // A stalled read stage must keep its pixel and its RAM data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_red_r) && $stable(mask_rdata)))
    else $error("stalled read stage lost data");

  // The last pixel of a frame returns the raster to the origin.
  assert property (@(posedge clk) disable iff (!rst_n)
    (img_acc && last_col && last_row) |=>
      (column_r == '0 && row_r == '0 && tile_row_base_r == '0))
    else $error("raster counters not cleared at frame end");

  // Every result moved to the output was shown before the next overwrite.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("unaccepted result dropped");

endmodule

`default_nettype wire

[tb/tiled_mask_brighten_test.sv]
`timescale 1ns / 100ps
// Testbench for tiled_mask_brighten: tile loads and image pixels checked
// against a cycle-free overlay predictor. Depends on tmb_pkg and the block RTL.
module tiled_mask_brighten_test;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       brightened;
    logic       frame_end;
  } pixel_result_t;

  // Tile rows loaded up front; random tile heights stay within them
  localparam int FILL_ROWS = 16;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [tmb_pkg::APB_AW-1:0]   paddr = '0;
  logic [tmb_pkg::APB_DW-1:0]   pwdata = '0;
  logic [tmb_pkg::APB_DW-1:0]   prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_operation = 1'b0;
  logic [7:0]                   in_red = '0;
  logic [7:0]                   in_green = '0;
  logic [7:0]                   in_blue = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_red;
  logic [7:0]                   out_green;
  logic [7:0]                   out_blue;
  logic                         out_brightened;
  logic                         out_frame_end;

  tiled_mask_brighten i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_brightened (out_brightened),
    .out_frame_end  (out_frame_end)
  );

  // Idle / stall percentages, set per test
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_off_request = 1'b0;
  int hold_off_left = 0;
  int error_count = 0;

  // Predictor state
  pixel_result_t pending_pixels[$];
  logic          mask_bits [tmb_pkg::MASK_DEPTH];
  logic [11:0]   load_ptr = '0;
  logic [11:0]   col_cnt = '0;
  logic [11:0]   row_cnt = '0;
  logic [5:0]    tile_col = '0;
  logic [5:0]    tile_row = '0;
  logic [11:0]   tile_row_base = '0;
  logic [12:0]   frame_w_reg = 13'd640;
  logic [12:0]   frame_h_reg = 13'd480;
  logic [6:0]    tile_w_reg = 7'd64;
  logic [6:0]    tile_h_reg = 7'd64;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off_request) begin
      hold_off_left = 300;
      hold_off_request = 1'b0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic int clamped_dim(int v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [7:0] scale_channel(logic [7:0] v);
    int s;
    s = (int'(v) * 29) / 20;
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  function automatic logic [7:0] rand_channel();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  // Overlay predictor: updates counters and queues the expected pixel
  task automatic model_overlay(tmb_pkg::op_t op, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b);
    int            fw;
    int            fh;
    int            tw;
    int            th;
    bit            hit;
    bit            last_col;
    bit            last_row;
    pixel_result_t res;
    fw = clamped_dim(int'(frame_w_reg), tmb_pkg::FRAME_DIM_MAX);
    fh = clamped_dim(int'(frame_h_reg), tmb_pkg::FRAME_DIM_MAX);
    tw = clamped_dim(int'(tile_w_reg), tmb_pkg::TILE_DIM_MAX);
    th = clamped_dim(int'(tile_h_reg), tmb_pkg::TILE_DIM_MAX);
    if (op == tmb_pkg::OP_LOAD) begin
      mask_bits[load_ptr] = (r == 0 && g == 0 && b == 0);
      if (int'(load_ptr) + 1 >= tw * th) load_ptr = '0;
      else load_ptr = load_ptr + 1'b1;
    end else begin
      hit = mask_bits[(int'(tile_row_base) + int'(tile_col)) % tmb_pkg::MASK_DEPTH];
      last_col = int'(col_cnt) + 1 >= fw;
      last_row = int'(row_cnt) + 1 >= fh;
      res.red        = hit ? scale_channel(r) : r;
      res.green      = hit ? scale_channel(g) : g;
      res.blue       = hit ? scale_channel(b) : b;
      res.brightened = hit;
      res.frame_end  = last_col && last_row;
      pending_pixels.push_back(res);
      if (!last_col) begin
        col_cnt = col_cnt + 1'b1;
        if (int'(tile_col) + 1 >= tw) tile_col = '0;
        else tile_col = tile_col + 1'b1;
      end else begin
        col_cnt = '0;
        tile_col = '0;
        if (last_row) begin
          row_cnt = '0;
          tile_row = '0;
          tile_row_base = '0;
        end else begin
          row_cnt = row_cnt + 1'b1;
          if (int'(tile_row) + 1 >= th) begin
            tile_row = '0;
            tile_row_base = '0;
          end else begin
            tile_row = tile_row + 1'b1;
            tile_row_base = 12'(int'(tile_row) * tw);
          end
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [7:0] expected, logic [7:0] actual);
    if (actual !== expected) begin
      error_count++;
      $error("%s: expected %0d, got %0d", name, expected, actual);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        error_count++;
        $error("unexpected result transaction");
      end else begin
        exp_px = pending_pixels.pop_front();
        check_field("out_red", exp_px.red, out_red);
        check_field("out_green", exp_px.green, out_green);
        check_field("out_blue", exp_px.blue, out_blue);
        check_field("out_brightened", 8'(exp_px.brightened), 8'(out_brightened));
        check_field("out_frame_end", 8'(exp_px.frame_end), 8'(out_frame_end));
      end
    end
  end

  task automatic send_item(tmb_pkg::op_t op, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_overlay(op, r, g, b);
  endtask

  // Tile pixel: half all-zero (mask set), rest mostly near zero
  task automatic send_tile_pixel();
    logic [7:0] ch [3];
    if ($urandom_range(1) == 0) begin
      send_item(tmb_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0);
    end else begin
      foreach (ch[i]) ch[i] = ($urandom_range(9) < 6) ? 8'd0 : rand_channel();
      send_item(tmb_pkg::OP_LOAD, ch[0], ch[1], ch[2]);
    end
  endtask

  task automatic send_image_pixel();
    send_item(tmb_pkg::OP_PIXEL, rand_channel(), rand_channel(), rand_channel());
  endtask

  // Lets in-flight pixels drain; loads give no result and are already written
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(tmb_pkg::reg_idx_t idx, int unsigned value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tmb_pkg::APB_AW'({idx, 2'b00});
    pwdata  <= tmb_pkg::APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tmb_pkg::REG_FRAME_WIDTH:  frame_w_reg = 13'(value);
      tmb_pkg::REG_FRAME_HEIGHT: frame_h_reg = 13'(value);
      tmb_pkg::REG_TILE_WIDTH:   tile_w_reg  = 7'(value);
      tmb_pkg::REG_TILE_HEIGHT:  tile_h_reg  = 7'(value);
      default: ;
    endcase
  endtask

  task automatic set_sizes(int fw, int fh, int tw, int th);
    write_reg(tmb_pkg::REG_FRAME_WIDTH, fw);
    write_reg(tmb_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(tmb_pkg::REG_TILE_WIDTH, tw);
    write_reg(tmb_pkg::REG_TILE_HEIGHT, th);
  endtask

  // Fill the top tile rows at full tile width, then wrap a few loads
  task automatic test_tile_fill();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_reg(tmb_pkg::REG_TILE_HEIGHT, FILL_ROWS);
    repeat (tmb_pkg::TILE_DIM_MAX * FILL_ROWS + 5) send_tile_pixel();
    wait_drained();
  endtask

  // Hit and miss pixels, saturation edge, frame end and frame wrap
  task automatic test_scaling();
    set_sizes(3, 2, 2, 1);
    // load index sits past the 2-entry tile: first load wraps it to 0
    send_item(tmb_pkg::OP_LOAD, 8'd9, 8'd9, 8'd9);
    send_item(tmb_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0);
    send_item(tmb_pkg::OP_LOAD, 8'd0, 8'd0, 8'd1);
    send_item(tmb_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(tmb_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd128);
    send_item(tmb_pkg::OP_PIXEL, 8'd176, 8'd175, 8'd14);
    send_item(tmb_pkg::OP_PIXEL, 8'd0, 8'd1, 8'd19);
    send_item(tmb_pkg::OP_PIXEL, 8'd13, 8'd138, 8'd20);
    send_item(tmb_pkg::OP_PIXEL, 8'd1, 8'd2, 8'd3);
    wait_drained();
  endtask

  // Zero registers act as one, oversized ones as the maximum
  task automatic test_dim_clamp();
    set_sizes(0, 8191, 127, 0);
    repeat (4) send_image_pixel();
    set_sizes(8191, 0, 0, 127);
    repeat (3) send_image_pixel();
    wait_drained();
  endtask

  // Registers lowered mid-frame below the current counter values
  task automatic test_counter_shrink();
    set_sizes(8, 4, 5, 3);
    repeat (6) send_image_pixel();
    write_reg(tmb_pkg::REG_FRAME_WIDTH, 3);
    write_reg(tmb_pkg::REG_TILE_WIDTH, 2);
    repeat (3) send_image_pixel();
    write_reg(tmb_pkg::REG_FRAME_HEIGHT, 1);
    write_reg(tmb_pkg::REG_TILE_HEIGHT, 1);
    repeat (2) send_image_pixel();
    wait_drained();
  endtask

  // Long receiver hold-off while the sender keeps offering pixels
  task automatic test_backpressure();
    set_sizes(5, 4, 3, 2);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_off_request = 1'b1;
    repeat (40) send_image_pixel();
    wait_drained();
  endtask

  function automatic int pick_frame_dim();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 0;
    if (pick < 14) return $urandom_range(8191, tmb_pkg::FRAME_DIM_MAX + 1);
    if (pick < 18) return tmb_pkg::FRAME_DIM_MAX;
    if (pick < 70) return $urandom_range(8, 1);
    return $urandom_range(40, 1);
  endfunction

  function automatic int pick_tile_dim();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 0;
    if (pick < 14) return $urandom_range(127, tmb_pkg::TILE_DIM_MAX + 1);
    if (pick < 22) return tmb_pkg::TILE_DIM_MAX;
    return $urandom_range(8, 1);
  endfunction

  // Heights never reach past the rows loaded at the start
  function automatic int pick_tile_height();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 0;
    if (pick < 22) return FILL_ROWS;
    return $urandom_range(8, 1);
  endfunction

  task automatic randomize_sizes();
    int area;
    set_sizes(pick_frame_dim(), pick_frame_dim(), pick_tile_dim(), pick_tile_height());
    area = clamped_dim(int'(tile_w_reg), tmb_pkg::TILE_DIM_MAX)
         * clamped_dim(int'(tile_h_reg), tmb_pkg::TILE_DIM_MAX);
    // sometimes reload a small tile in full so its pattern is fresh
    if (area <= 256 && $urandom_range(2) == 0)
      repeat (area + 1) send_tile_pixel();
  endtask

  task automatic test_random(int src_pct, int sink_pct, int count);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) randomize_sizes();
      if ($urandom_range(99) < 20) send_tile_pixel();
      else send_image_pixel();
    end
    wait_drained();
  endtask

  task automatic finish_run();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_pixels.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      error_count++;
      $error("%0d expected results never arrived", pending_pixels.size());
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tile_fill();
    test_scaling();
    test_dim_clamp();
    test_counter_shrink();
    test_backpressure();
    test_random(0, 0, 250);
    test_random(85, 0, 250);
    test_random(0, 85, 250);
    test_random(38, 38, 250);
    finish_run();
  end

endmodule

[filelist.f]
hdl/tmb_pkg.sv
hdl/tmb_ram.sv
hdl/tiled_mask_brighten.sv
tb/tiled_mask_brighten_test.sv
